[rtl/hwip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwip_pkg
// Shared widths, register map, reset values and saturation helpers for the
// heading and wheel incremental PID block.
// ----------------------------------------------------------------------------
package hwip_pkg;

  localparam int GAIN_FRAC_BITS  = 8;
  localparam int ANGLE_FRAC_BITS = 6;

  localparam int GAIN_W   = 12;
  localparam int SPEED_W  = 10;
  localparam int ANGLE_W  = 15;
  localparam int COUNT_W  = 16;
  localparam int DUTY_W   = 11;
  localparam int ERR_W    = 18;
  localparam int ACC_W    = 32;
  localparam int RAW_W    = 35;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    REG_SPEED_KP   = 3'd0,
    REG_SPEED_KI   = 3'd1,
    REG_SPEED_KD   = 3'd2,
    REG_HEADING_KP = 3'd3,
    REG_HEADING_KI = 3'd4,
    REG_HEADING_KD = 3'd5,
    REG_BASE_SPEED = 3'd6,
    REG_DUTY_LIMIT = 3'd7
  } cfg_reg_e;

  localparam logic [GAIN_W-1:0]  SPEED_KP_RST   = 12'd768;
  localparam logic [GAIN_W-1:0]  SPEED_KI_RST   = 12'd0;
  localparam logic [GAIN_W-1:0]  SPEED_KD_RST   = 12'd102;
  localparam logic [GAIN_W-1:0]  HEADING_KP_RST = 12'd512;
  localparam logic [GAIN_W-1:0]  HEADING_KI_RST = 12'd0;
  localparam logic [GAIN_W-1:0]  HEADING_KD_RST = 12'd0;
  localparam logic [SPEED_W-1:0] BASE_SPEED_RST = 10'd90;
  localparam logic [SPEED_W-1:0] DUTY_LIMIT_RST = 10'd999;

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [RAW_W-1:0] x);
    logic signed [RAW_W-1:0] hi;
    logic signed [RAW_W-1:0] lo;
    hi = RAW_W'({1'b0, {(ERR_W-1){1'b1}}});
    lo = -hi - RAW_W'(1);
    if (x > hi) begin
      return {1'b0, {(ERR_W-1){1'b1}}};
    end else if (x < lo) begin
      return {1'b1, {(ERR_W-1){1'b0}}};
    end else begin
      return x[ERR_W-1:0];
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+5:0] x);
    logic signed [ACC_W+5:0] hi;
    logic signed [ACC_W+5:0] lo;
    hi = (ACC_W+6)'({1'b0, {(ACC_W-1){1'b1}}});
    lo = -hi - (ACC_W+6)'(1);
    if (x > hi) begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end else if (x < lo) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      return x[ACC_W-1:0];
    end
  endfunction

endpackage

[rtl/heading_and_wheel_incremental_pid.sv]
`timescale 1ns / 1ps
// one item at a time: the input is stalled from the transfer until the
//   result is clamped, as the single shared multiplier serves every step
//   (three products per PID, three PIDs, plus error, update and clamp steps)
// a finished result waits in the output register while the next item is taken
// reset clears gains to defaults and all error history and accumulators
// ----------------------------------------------------------------------------
// heading_and_wheel_incremental_pid
// Cascaded velocity-form PID: heading loop gives a steering bias, two wheel
// loops give clamped duties. One multiplier under a small sequencer.
// ----------------------------------------------------------------------------
module heading_and_wheel_incremental_pid
  import hwip_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [ANGLE_W-1:0] heading_i,
  input  logic signed [ANGLE_W-1:0] heading_goal_i,
  input  logic signed [COUNT_W-1:0] left_count_i,
  input  logic signed [COUNT_W-1:0] right_count_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [DUTY_W-1:0]  left_duty_o,
  output logic signed [DUTY_W-1:0]  right_duty_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_MAC,
    S_UPD,
    S_CLMP
  } state_e;

  typedef enum logic [1:0] {
    PID_HEAD  = 2'd0,
    PID_LEFT  = 2'd1,
    PID_RIGHT = 2'd2
  } pid_sel_e;

  localparam int MUL_A_W = GAIN_W + 1;
  localparam int MUL_B_W = ERR_W + 3;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int BIAS_W  = ACC_W + 1;
  localparam logic signed [BIAS_W-1:0] BIAS_HALF = BIAS_W'((1 << ANGLE_FRAC_BITS) >> 1);
  localparam logic signed [SUM_W-1:0]  SUM_HALF  = SUM_W'((1 << GAIN_FRAC_BITS) >> 1);

  state_e   state_q;
  pid_sel_e sel_q;
  logic [1:0] cnt_q;

  logic [GAIN_W-1:0]  speed_kp_q, speed_ki_q, speed_kd_q;
  logic [GAIN_W-1:0]  heading_kp_q, heading_ki_q, heading_kd_q;
  logic [SPEED_W-1:0] base_speed_q, duty_limit_q;

  logic signed [ANGLE_W-1:0] heading_q, goal_q;
  logic signed [COUNT_W-1:0] left_count_q, right_count_q;

  logic signed [ERR_W-1:0]  err_q;
  logic signed [ERR_W-1:0]  p1_q  [3];
  logic signed [ERR_W-1:0]  p2_q  [3];
  logic signed [ACC_W-1:0]  acc_q [3];
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  sum_q;

  logic                     out_valid_q;
  logic signed [DUTY_W-1:0] left_duty_q, right_duty_q;

  logic                      in_xfer;
  logic                      cfg_wr;
  logic signed [BIAS_W-1:0]  bias_w;
  logic signed [SPEED_W:0]   base_s;
  logic signed [RAW_W-1:0]   raw_err;
  logic [GAIN_W-1:0]         gain_w;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_w;
  logic signed [SUM_W-1:0]   inc_w;
  logic signed [ACC_W+5:0]   acc_sum;
  logic signed [ERR_W-1:0]   p1_sel, p2_sel;
  logic signed [ACC_W-1:0]   acc_sel;

  function automatic logic signed [DUTY_W-1:0] clamp_duty(
    input logic signed [ACC_W-1:0] acc,
    input logic [SPEED_W-1:0]      lim
  );
    logic signed [ACC_W-1:0] hi;
    hi = ACC_W'(signed'({1'b0, lim}));
    if (acc > hi) begin
      return DUTY_W'(hi);
    end else if (acc < -hi) begin
      return DUTY_W'(-hi);
    end else begin
      return acc[DUTY_W-1:0];
    end
  endfunction

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign left_duty_o  = left_duty_q;
  assign right_duty_o = right_duty_q;
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;

  assign p1_sel  = p1_q[sel_q];
  assign p2_sel  = p2_q[sel_q];
  assign acc_sel = acc_q[sel_q];

  // steering bias from the heading accumulator, round half up
  assign bias_w = (BIAS_W'(acc_q[PID_HEAD]) + BIAS_HALF) >>> ANGLE_FRAC_BITS;
  assign base_s = signed'({1'b0, base_speed_q});

  always_comb begin
    case (sel_q)
      PID_HEAD:  raw_err = RAW_W'(goal_q) - RAW_W'(heading_q);
      PID_LEFT:  raw_err = RAW_W'(base_s) - RAW_W'(bias_w) - RAW_W'(left_count_q);
      PID_RIGHT: raw_err = RAW_W'(base_s) + RAW_W'(bias_w) - RAW_W'(right_count_q);
      default:   raw_err = '0;
    endcase
  end

  // shared multiplier: proportional, integral, derivative term by count
  always_comb begin
    case (cnt_q)
      2'd0: begin
        gain_w = (sel_q == PID_HEAD) ? heading_kp_q : speed_kp_q;
        mul_b  = MUL_B_W'(err_q) - MUL_B_W'(p1_sel);
      end
      2'd1: begin
        gain_w = (sel_q == PID_HEAD) ? heading_ki_q : speed_ki_q;
        mul_b  = MUL_B_W'(err_q);
      end
      2'd2: begin
        gain_w = (sel_q == PID_HEAD) ? heading_kd_q : speed_kd_q;
        mul_b  = MUL_B_W'(err_q) - (MUL_B_W'(p1_sel) <<< 1) + MUL_B_W'(p2_sel);
      end
      default: begin
        gain_w = '0;
        mul_b  = '0;
      end
    endcase
  end

  assign mul_a   = signed'({1'b0, gain_w});
  assign prod_w  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign inc_w   = (sum_q + SUM_HALF) >>> GAIN_FRAC_BITS;
  assign acc_sum = (ACC_W+6)'(acc_sel) + (ACC_W+6)'(inc_w);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_kp_q   <= SPEED_KP_RST;
      speed_ki_q   <= SPEED_KI_RST;
      speed_kd_q   <= SPEED_KD_RST;
      heading_kp_q <= HEADING_KP_RST;
      heading_ki_q <= HEADING_KI_RST;
      heading_kd_q <= HEADING_KD_RST;
      base_speed_q <= BASE_SPEED_RST;
      duty_limit_q <= DUTY_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[ADDR_W-1:2]))
        REG_SPEED_KP:   speed_kp_q   <= pwdata[GAIN_W-1:0];
        REG_SPEED_KI:   speed_ki_q   <= pwdata[GAIN_W-1:0];
        REG_SPEED_KD:   speed_kd_q   <= pwdata[GAIN_W-1:0];
        REG_HEADING_KP: heading_kp_q <= pwdata[GAIN_W-1:0];
        REG_HEADING_KI: heading_ki_q <= pwdata[GAIN_W-1:0];
        REG_HEADING_KD: heading_kd_q <= pwdata[GAIN_W-1:0];
        REG_BASE_SPEED: base_speed_q <= pwdata[SPEED_W-1:0];
        REG_DUTY_LIMIT: duty_limit_q <= pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[ADDR_W-1:2]))
      REG_SPEED_KP:   prdata = DATA_W'(speed_kp_q);
      REG_SPEED_KI:   prdata = DATA_W'(speed_ki_q);
      REG_SPEED_KD:   prdata = DATA_W'(speed_kd_q);
      REG_HEADING_KP: prdata = DATA_W'(heading_kp_q);
      REG_HEADING_KI: prdata = DATA_W'(heading_ki_q);
      REG_HEADING_KD: prdata = DATA_W'(heading_kd_q);
      REG_BASE_SPEED: prdata = DATA_W'(base_speed_q);
      REG_DUTY_LIMIT: prdata = DATA_W'(duty_limit_q);
      default:        prdata = '0;
    endcase
  end

  // sequencer and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      sel_q         <= PID_HEAD;
      cnt_q         <= '0;
      heading_q     <= '0;
      goal_q        <= '0;
      left_count_q  <= '0;
      right_count_q <= '0;
      err_q         <= '0;
      prod_q        <= '0;
      sum_q         <= '0;
      out_valid_q   <= 1'b0;
      left_duty_q   <= '0;
      right_duty_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        p1_q[i]  <= '0;
        p2_q[i]  <= '0;
        acc_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_CLMP) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            heading_q     <= heading_i;
            goal_q        <= heading_goal_i;
            left_count_q  <= left_count_i;
            right_count_q <= right_count_i;
            sel_q         <= PID_HEAD;
            state_q       <= S_ERR;
          end
        end
        S_ERR: begin
          err_q   <= sat_err(raw_err);
          sum_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_MAC;
        end
        S_MAC: begin
          if (cnt_q != 2'd3) begin
            prod_q <= prod_w;
          end
          if (cnt_q != 2'd0) begin
            sum_q <= sum_q + SUM_W'(prod_q);
          end
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          acc_q[sel_q] <= sat_acc(acc_sum);
          p2_q[sel_q]  <= p1_sel;
          p1_q[sel_q]  <= err_q;
          case (sel_q)
            PID_HEAD: begin
              sel_q   <= PID_LEFT;
              state_q <= S_ERR;
            end
            PID_LEFT: begin
              sel_q   <= PID_RIGHT;
              state_q <= S_ERR;
            end
            default: begin
              state_q <= S_CLMP;
            end
          endcase
        end
        S_CLMP: begin
          if (!out_valid_q || !out_stall_i) begin
            left_duty_q  <= clamp_duty(acc_q[PID_LEFT], duty_limit_q);
            right_duty_q <= clamp_duty(acc_q[PID_RIGHT], duty_limit_q);
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/hwip_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwip_chk
// Port-level checks on the heading and wheel incremental PID block.
// ----------------------------------------------------------------------------
module hwip_chk
  import hwip_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [DUTY_W-1:0]  left_duty_o,
  input logic signed [DUTY_W-1:0]  right_duty_o
);

  // a result stays offered until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its duties
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(left_duty_o) && $stable(right_duty_o))
    else $error("stalled duties changed");

  // the block is busy right after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  // a new result only appears at the end of busy work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work");

  // the clamp never yields the most negative code
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_duty_o != {1'b1, {(DUTY_W-1){1'b0}}}) &&
                    (right_duty_o != {1'b1, {(DUTY_W-1){1'b0}}}))
    else $error("duty outside clamp");

endmodule

bind heading_and_wheel_incremental_pid hwip_chk u_hwip_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .left_duty_o  (left_duty_o),
  .right_duty_o (right_duty_o)
);

[bench/drive_pid_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_pid_checker
// Watches the tick channel, the duty channel and the register port of the
// cascaded heading and wheel PID. Keeps its own copy of the gains and of the
// loop history, predicts the duty pair of every accepted tick and compares
// each duty transfer with the oldest prediction still pending.
// ----------------------------------------------------------------------------
module drive_pid_checker
  import hwip_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic signed [ANGLE_W-1:0] heading_i,
  input  logic signed [ANGLE_W-1:0] heading_goal_i,
  input  logic signed [COUNT_W-1:0] left_count_i,
  input  logic signed [COUNT_W-1:0] right_count_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [DUTY_W-1:0]  left_duty_i,
  input  logic signed [DUTY_W-1:0]  right_duty_i,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  input  logic                      pready,
  output int                        mismatch_count_o,
  output int                        duties_pending_o
);

  localparam longint ERR_HI     = (longint'(1) << (ERR_W - 1)) - 1;
  localparam longint ERR_LO     = -ERR_HI - 1;
  localparam longint ACC_HI     = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint ACC_LO     = -ACC_HI - 1;
  localparam longint GAIN_HALF  = longint'(1) << (GAIN_FRAC_BITS - 1);
  localparam longint ANGLE_HALF = (longint'(1) << ANGLE_FRAC_BITS) >> 1;

  typedef enum int {
    LOOP_HEADING,
    LOOP_LEFT,
    LOOP_RIGHT
  } pid_loop_e;

  typedef struct packed {
    logic signed [DUTY_W-1:0] left;
    logic signed [DUTY_W-1:0] right;
  } duty_pair_t;

  logic [GAIN_W-1:0]  speed_kp;
  logic [GAIN_W-1:0]  speed_ki;
  logic [GAIN_W-1:0]  speed_kd;
  logic [GAIN_W-1:0]  heading_kp;
  logic [GAIN_W-1:0]  heading_ki;
  logic [GAIN_W-1:0]  heading_kd;
  logic [SPEED_W-1:0] base_speed;
  logic [SPEED_W-1:0] duty_limit;

  longint     err_last[3];
  longint     err_older[3];
  longint     accum[3];
  duty_pair_t predicted_duties[$];
  duty_pair_t oldest;
  int         mismatches;
  int         duties_seen;

  function automatic longint clamp(longint x, longint lo, longint hi);
    if (x < lo) begin
      return lo;
    end
    if (x > hi) begin
      return hi;
    end
    return x;
  endfunction

  // velocity form: accumulate the rounded increment, then shift the history
  function automatic void pid_advance(pid_loop_e loop, longint e, longint kp,
                                      longint ki, longint kd);
    longint sum;
    sum = kp * (e - err_last[loop]) + ki * e
        + kd * (e - 2 * err_last[loop] + err_older[loop]);
    accum[loop] = clamp(accum[loop] + ((sum + GAIN_HALF) >>> GAIN_FRAC_BITS),
                        ACC_LO, ACC_HI);
    err_older[loop] = err_last[loop];
    err_last[loop]  = e;
  endfunction

  function automatic duty_pair_t advance_drive(longint heading, longint goal,
                                               longint lc, longint rc);
    longint     bias;
    longint     lim;
    duty_pair_t d;
    pid_advance(LOOP_HEADING, clamp(goal - heading, ERR_LO, ERR_HI),
                heading_kp, heading_ki, heading_kd);
    bias = (accum[LOOP_HEADING] + ANGLE_HALF) >>> ANGLE_FRAC_BITS;
    pid_advance(LOOP_LEFT, clamp(longint'(base_speed) - bias - lc, ERR_LO, ERR_HI),
                speed_kp, speed_ki, speed_kd);
    pid_advance(LOOP_RIGHT, clamp(longint'(base_speed) + bias - rc, ERR_LO, ERR_HI),
                speed_kp, speed_ki, speed_kd);
    lim = longint'(duty_limit);
    d.left  = DUTY_W'(clamp(accum[LOOP_LEFT], -lim, lim));
    d.right = DUTY_W'(clamp(accum[LOOP_RIGHT], -lim, lim));
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_kp   = SPEED_KP_RST;
      speed_ki   = SPEED_KI_RST;
      speed_kd   = SPEED_KD_RST;
      heading_kp = HEADING_KP_RST;
      heading_ki = HEADING_KI_RST;
      heading_kd = HEADING_KD_RST;
      base_speed = BASE_SPEED_RST;
      duty_limit = DUTY_LIMIT_RST;
      foreach (accum[i]) begin
        err_last[i]  = 0;
        err_older[i] = 0;
        accum[i]     = 0;
      end
      predicted_duties.delete();
      mismatches  = 0;
      duties_seen = 0;
      mismatch_count_o <= 0;
      duties_pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[ADDR_W-1:2]))
          REG_SPEED_KP:   speed_kp   = pwdata[GAIN_W-1:0];
          REG_SPEED_KI:   speed_ki   = pwdata[GAIN_W-1:0];
          REG_SPEED_KD:   speed_kd   = pwdata[GAIN_W-1:0];
          REG_HEADING_KP: heading_kp = pwdata[GAIN_W-1:0];
          REG_HEADING_KI: heading_ki = pwdata[GAIN_W-1:0];
          REG_HEADING_KD: heading_kd = pwdata[GAIN_W-1:0];
          REG_BASE_SPEED: base_speed = pwdata[SPEED_W-1:0];
          REG_DUTY_LIMIT: duty_limit = pwdata[SPEED_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        duties_seen++;
        if (predicted_duties.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("duty transfer %0d with no tick pending: left %0d right %0d",
                     duties_seen, left_duty_i, right_duty_i);
          end
        end else begin
          oldest = predicted_duties.pop_front();
          if (oldest.left !== left_duty_i || oldest.right !== right_duty_i) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("duty transfer %0d: left exp %0d got %0d, right exp %0d got %0d",
                       duties_seen, oldest.left, left_duty_i, oldest.right,
                       right_duty_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predicted_duties.push_back(advance_drive(longint'(heading_i),
                                                 longint'(heading_goal_i),
                                                 longint'(left_count_i),
                                                 longint'(right_count_i)));
      end
      mismatch_count_o <= mismatches;
      duties_pending_o <= predicted_duties.size();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives heading ticks and register writes into the cascaded heading and
// wheel PID with random gaps and output stalls, over several gain settings
// including the extremes and a long windup into accumulator saturation.
// The checker beside the block predicts and compares every duty transfer.
// ----------------------------------------------------------------------------
module tb_top;
  import hwip_pkg::*;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LO = {1'b1, {(ANGLE_W-1){1'b0}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_HI = ~ANGLE_LO;
  localparam logic signed [COUNT_W-1:0] COUNT_LO = {1'b1, {(COUNT_W-1){1'b0}}};
  localparam logic signed [COUNT_W-1:0] COUNT_HI = ~COUNT_LO;
  localparam int ANGLE_SPAN = 11520;
  localparam int GAIN_MAX   = 4095;
  localparam int SPEED_MAX  = 1023;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] heading;
    logic signed [ANGLE_W-1:0] heading_goal;
    logic signed [COUNT_W-1:0] left_count;
    logic signed [COUNT_W-1:0] right_count;
  } drive_tick_t;

  typedef enum int {
    TICK_NEAR,
    TICK_FULL,
    TICK_HELD
  } tick_kind_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [ANGLE_W-1:0] heading_i;
  logic signed [ANGLE_W-1:0] heading_goal_i;
  logic signed [COUNT_W-1:0] left_count_i;
  logic signed [COUNT_W-1:0] right_count_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [DUTY_W-1:0]  left_duty_o;
  logic signed [DUTY_W-1:0]  right_duty_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  int mismatch_count;
  int duties_pending;
  int cur_base;
  bit steady;

  heading_and_wheel_incremental_pid dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .heading_i      (heading_i),
    .heading_goal_i (heading_goal_i),
    .left_count_i   (left_count_i),
    .right_count_i  (right_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_duty_o    (left_duty_o),
    .right_duty_o   (right_duty_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  drive_pid_checker u_drive_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .heading_i        (heading_i),
    .heading_goal_i   (heading_goal_i),
    .left_count_i     (left_count_i),
    .right_count_i    (right_count_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .left_duty_i      (left_duty_o),
    .right_duty_i     (right_duty_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .mismatch_count_o (mismatch_count),
    .duties_pending_o (duties_pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int tick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int flow_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 8);
    end
    return $urandom_range(100, 400);
  endfunction

  // receiver: stall bursts between free-running stretches
  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      out_stall_i <= 1'b1;
      repeat (stall_len()) @(posedge clk_i);
      out_stall_i <= 1'b0;
      repeat (flow_len()) @(posedge clk_i);
    end
  end

  // one tick transfer, then a random gap
  task automatic drive_tick(input drive_tick_t t);
    int gap;
    in_valid_i     <= 1'b1;
    heading_i      <= t.heading;
    heading_goal_i <= t.heading_goal;
    left_count_i   <= t.left_count;
    right_count_i  <= t.right_count;
    do @(posedge clk_i); while (in_stall_o);
    gap = tick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic issue(input int h, input int g, input int lc, input int rc);
    drive_tick_t t;
    t.heading      = ANGLE_W'(h);
    t.heading_goal = ANGLE_W'(g);
    t.left_count   = COUNT_W'(lc);
    t.right_count  = COUNT_W'(rc);
    drive_tick(t);
  endtask

  task automatic wait_for_duties();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (duties_pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e r, input int unsigned v);
    int unsigned w;
    w = (r == REG_BASE_SPEED || r == REG_DUTY_LIMIT) ? SPEED_W : GAIN_W;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({r, 2'b00});
    // junk above the register width must be dropped
    pwdata  <= $urandom_range(0, 1) ? (($urandom << w) | v) : v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_loops(input int skp, input int ski, input int skd,
                               input int hkp, input int hki, input int hkd,
                               input int base, input int lim);
    write_reg(REG_SPEED_KP, skp);
    write_reg(REG_SPEED_KI, ski);
    write_reg(REG_SPEED_KD, skd);
    write_reg(REG_HEADING_KP, hkp);
    write_reg(REG_HEADING_KI, hki);
    write_reg(REG_HEADING_KD, hkd);
    write_reg(REG_BASE_SPEED, base);
    write_reg(REG_DUTY_LIMIT, lim);
    cur_base = base;
  endtask

  // back-to-back ticks with the heading error pinned near one extreme
  task automatic hold_error(input int n, input bit up);
    drive_tick_t t;
    steady = 1'b1;
    repeat (n) begin
      t.heading      = up ? ANGLE_LO + ANGLE_W'($urandom_range(0, 63))
                          : ANGLE_HI - ANGLE_W'($urandom_range(0, 63));
      t.heading_goal = up ? ANGLE_HI - ANGLE_W'($urandom_range(0, 63))
                          : ANGLE_LO + ANGLE_W'($urandom_range(0, 63));
      t.left_count   = COUNT_W'($urandom);
      t.right_count  = COUNT_W'($urandom);
      drive_tick(t);
    end
    steady = 1'b0;
  endtask

  task automatic run_random(input int n);
    int          done;
    int          len;
    int          pick;
    int          k;
    tick_kind_e  kind;
    drive_tick_t t;
    drive_tick_t held;
    done = 0;
    while (done < n) begin
      pick   = $urandom_range(0, 9);
      kind   = pick < 5 ? TICK_NEAR : (pick < 8 ? TICK_FULL : TICK_HELD);
      len    = $urandom_range(3, 25);
      steady = ($urandom_range(0, 4) == 0);
      held.heading      = $urandom_range(0, 1) ? ANGLE_LO : ANGLE_HI;
      held.heading_goal = ~held.heading;
      held.left_count   = $urandom_range(0, 1) ? COUNT_LO : COUNT_HI;
      held.right_count  = ~held.left_count;
      for (k = 0; k < len && done < n; k++) begin
        case (kind)
          TICK_NEAR: begin
            t.heading      = ANGLE_W'(int'($urandom_range(0, 2 * ANGLE_SPAN)) - ANGLE_SPAN);
            t.heading_goal = t.heading + ANGLE_W'(int'($urandom_range(0, 1280)) - 640);
            t.left_count   = COUNT_W'(cur_base + int'($urandom_range(0, 80)) - 40);
            t.right_count  = COUNT_W'(cur_base + int'($urandom_range(0, 80)) - 40);
          end
          TICK_FULL: begin
            t.heading      = ANGLE_W'($urandom);
            t.heading_goal = ANGLE_W'($urandom);
            t.left_count   = COUNT_W'($urandom);
            t.right_count  = COUNT_W'($urandom);
          end
          default: t = held;
        endcase
        drive_tick(t);
        done++;
        if ($urandom_range(0, 119) == 0) begin
          wait_for_duties();
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    int gain_top;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    heading_i      <= '0;
    heading_goal_i <= '0;
    left_count_i   <= '0;
    right_count_i  <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    cur_base = BASE_SPEED_RST;
    steady   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset gains: field extremes and out-of-range angles
    issue(0, 0, 0, 0);
    issue(0, 0, 90, 90);
    issue(-ANGLE_SPAN, ANGLE_SPAN, 0, 0);
    issue(ANGLE_SPAN, -ANGLE_SPAN, 0, 0);
    issue(ANGLE_LO, ANGLE_HI, 0, 0);
    issue(ANGLE_HI, ANGLE_LO, 0, 0);
    issue(0, 0, COUNT_LO, COUNT_HI);
    issue(0, 0, COUNT_HI, COUNT_LO);
    issue(100, 164, 90, 90);
    issue(-64, -64, 85, 95);
    wait_for_duties();

    // full gains: the bias grows while the heading error is held, then reverses
    program_loops(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX,
                  SPEED_MAX, SPEED_MAX);
    repeat (6) issue(ANGLE_LO, ANGLE_HI, COUNT_LO, COUNT_HI);
    repeat (6) issue(ANGLE_HI, ANGLE_LO, COUNT_HI, COUNT_LO);
    wait_for_duties();

    // zero duty limit while the loops keep integrating
    program_loops($urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX),
                  $urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX),
                  $urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX),
                  $urandom_range(0, SPEED_MAX), 0);
    run_random(20);
    wait_for_duties();

    program_loops(0, 0, 0, 0, 0, 0, 0, SPEED_MAX);
    run_random(20);
    wait_for_duties();

    repeat (4) begin
      gain_top = $urandom_range(0, 1) ? 1023 : GAIN_MAX;
      program_loops($urandom_range(0, gain_top), $urandom_range(0, gain_top),
                    $urandom_range(0, gain_top), $urandom_range(0, gain_top),
                    $urandom_range(0, gain_top), $urandom_range(0, gain_top),
                    $urandom_range(0, SPEED_MAX), $urandom_range(0, SPEED_MAX));
      run_random(20);
      wait_for_duties();
    end

    program_loops(SPEED_KP_RST, SPEED_KI_RST, SPEED_KD_RST, HEADING_KP_RST,
                  HEADING_KI_RST, HEADING_KD_RST, BASE_SPEED_RST, DUTY_LIMIT_RST);
    run_random(20);
    wait_for_duties();

    // long windup drives the wheel accumulators into saturation
    program_loops(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX,
                  SPEED_MAX, SPEED_MAX);
    hold_error(1100, 1'b1);
    hold_error(40, 1'b0);
    run_random(20);
    wait_for_duties();

    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && duties_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
